>>> rtl/core/edfd_pkg.sv
// Shared types and constants for the escaped field message deframer.
package edfd_pkg;

  localparam int unsigned PARAM_LEN_LIMIT = 1023;
  localparam int unsigned PARAM_LEN_CAP   = (PARAM_LEN_LIMIT > 1023) ? 1023 : PARAM_LEN_LIMIT;

  localparam int unsigned TokenMax   = 5;
  localparam int unsigned TDataWidth = 40;

  localparam logic [7:0] CHAR_AMP    = 8'h26;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_MSG_START  = 3'd1,
    EV_PARAM_END  = 3'd2,
    EV_LAST_END   = 3'd3,
    EV_LEN_ERROR  = 3'd4,
    EV_ABORTED    = 3'd5
  } event_e;

  typedef struct packed {
    event_e             event_res;
    logic [7:0]         data_byte;
    logic [9:0]         param_length;
    logic signed [17:0] count_value;
  } result_t;

endpackage

>>> rtl/core/edfd_core.sv
// Deframer state registers and per-byte next-state and result logic.
module edfd_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 action_i,
  input  logic [7:0]           in_byte_i,
  output logic                 res_valid_o,
  output edfd_pkg::result_t    res_o
);

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_LEN   = 2'd1,
    PH_PARAM = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    NP_SPACE  = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_DONE   = 2'd3
  } num_phase_e;

  phase_e      phase_q, phase_d;
  num_phase_e  num_phase_q, num_phase_d;
  logic        amp_seen_q, amp_seen_d;
  logic        esc_q, esc_d;
  logic [2:0]  token_chars_q, token_chars_d;
  logic        neg_q, neg_d;
  logic [16:0] num_val_q, num_val_d;
  logic [16:0] params_left_q, params_left_d;
  logic [9:0]  param_bytes_q, param_bytes_d;

  logic        do_clear;
  logic        go_len;
  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit_val;
  logic [20:0] num_times_ten;

  assign is_digit      = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_space      = (in_byte_i == 8'h20) || ((in_byte_i >= 8'h09) && (in_byte_i <= 8'h0D));
  assign digit_val     = in_byte_i[3:0];
  assign num_times_ten = {1'b0, num_val_q, 3'b000} + {3'b000, num_val_q, 1'b0}
                         + {17'd0, digit_val};

  always_comb begin
    phase_d       = phase_q;
    num_phase_d   = num_phase_q;
    amp_seen_d    = amp_seen_q;
    esc_d         = esc_q;
    token_chars_d = token_chars_q;
    neg_d         = neg_q;
    num_val_d     = num_val_q;
    params_left_d = params_left_q;
    param_bytes_d = param_bytes_q;
    do_clear      = 1'b0;
    go_len        = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (accept_i) begin
      if (action_i) begin
        do_clear = 1'b1;
      end else begin
        case (phase_q)
          PH_LEN: begin
            if (in_byte_i == edfd_pkg::CHAR_SEMI) begin
              res_valid_o = 1'b1;
              if (num_val_q == '0) begin
                do_clear        = 1'b1;
                res_o.event_res = edfd_pkg::EV_LEN_ERROR;
              end else begin
                res_o.event_res   = edfd_pkg::EV_MSG_START;
                res_o.count_value = neg_q ? -$signed({1'b0, num_val_q})
                                          : $signed({1'b0, num_val_q});
                params_left_d     = (!neg_q && (num_val_q >= 17'd2)) ?
                                    (num_val_q - 17'd1) : 17'd1;
                param_bytes_d     = '0;
                esc_d             = 1'b0;
                phase_d           = PH_PARAM;
              end
            end else if (token_chars_q >= 3'(edfd_pkg::TokenMax)) begin
              res_valid_o     = 1'b1;
              res_o.event_res = edfd_pkg::EV_LEN_ERROR;
              do_clear        = 1'b1;
            end else begin
              token_chars_d = token_chars_q + 3'd1;
              case (num_phase_q)
                NP_SPACE: begin
                  if (is_space) begin
                    num_phase_d = NP_SPACE;
                  end else if ((in_byte_i == 8'h2B) || (in_byte_i == 8'h2D)) begin
                    neg_d       = (in_byte_i == 8'h2D);
                    num_phase_d = NP_SIGN;
                  end else if (is_digit) begin
                    num_val_d   = {13'd0, digit_val};
                    num_phase_d = NP_DIGITS;
                  end else begin
                    num_phase_d = NP_DONE;
                  end
                end
                NP_SIGN, NP_DIGITS: begin
                  if (is_digit) begin
                    num_val_d   = num_times_ten[16:0];
                    num_phase_d = NP_DIGITS;
                  end else begin
                    num_phase_d = NP_DONE;
                  end
                end
                default: begin
                  num_phase_d = NP_DONE;
                end
              endcase
            end
          end
          PH_PARAM: begin
            if (!esc_q && (in_byte_i == edfd_pkg::CHAR_SEMI)) begin
              res_valid_o        = 1'b1;
              res_o.param_length = param_bytes_q;
              if (params_left_q <= 17'd1) begin
                res_o.event_res = edfd_pkg::EV_LAST_END;
                do_clear        = 1'b1;
              end else begin
                res_o.event_res = edfd_pkg::EV_PARAM_END;
                params_left_d   = params_left_q - 17'd1;
                param_bytes_d   = '0;
              end
            end else if (!esc_q && (in_byte_i == edfd_pkg::CHAR_BSLASH)) begin
              esc_d = 1'b1;
            end else if (!esc_q && (in_byte_i == edfd_pkg::CHAR_AMP)) begin
              res_valid_o     = 1'b1;
              res_o.event_res = edfd_pkg::EV_ABORTED;
              do_clear        = 1'b1;
            end else begin
              esc_d           = 1'b0;
              res_valid_o     = 1'b1;
              res_o.event_res = edfd_pkg::EV_PAYLOAD;
              res_o.data_byte = in_byte_i;
              if (param_bytes_q < 10'(edfd_pkg::PARAM_LEN_CAP)) begin
                param_bytes_d = param_bytes_q + 10'd1;
              end
            end
          end
          default: begin
            phase_d = PH_HEAD;
            if (amp_seen_q) begin
              if (in_byte_i == edfd_pkg::CHAR_SEMI) begin
                do_clear = 1'b1;
                go_len   = 1'b1;
              end else if (in_byte_i != edfd_pkg::CHAR_AMP) begin
                amp_seen_d = 1'b0;
              end
            end else if (in_byte_i == edfd_pkg::CHAR_AMP) begin
              amp_seen_d = 1'b1;
            end
          end
        endcase
      end
    end

    if (do_clear) begin
      phase_d       = go_len ? PH_LEN : PH_HEAD;
      num_phase_d   = NP_SPACE;
      amp_seen_d    = 1'b0;
      esc_d         = 1'b0;
      token_chars_d = '0;
      neg_d         = 1'b0;
      num_val_d     = '0;
      params_left_d = '0;
      param_bytes_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEAD;
      num_phase_q   <= NP_SPACE;
      amp_seen_q    <= 1'b0;
      esc_q         <= 1'b0;
      token_chars_q <= '0;
      neg_q         <= 1'b0;
      num_val_q     <= '0;
      params_left_q <= '0;
      param_bytes_q <= '0;
    end else begin
      phase_q       <= phase_d;
      num_phase_q   <= num_phase_d;
      amp_seen_q    <= amp_seen_d;
      esc_q         <= esc_d;
      token_chars_q <= token_chars_d;
      neg_q         <= neg_d;
      num_val_q     <= num_val_d;
      params_left_q <= params_left_d;
      param_bytes_q <= param_bytes_d;
    end
  end

endmodule

>>> rtl/core/edfd_out_reg.sv
// Result register holding one transaction for the master side.
module edfd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  edfd_pkg::result_t    res_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output logic                 free_o,
  output edfd_pkg::result_t    res_o
);

  logic              valid_q, valid_d;
  edfd_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/core/escaped_field_message_deframer_unit.sv
// Top level of the escaped field message deframer.
// A result appears on the master side in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle; input stalls only while a result waits.
// The bytes that give no result (header, token, backslash, flush) are still accepted as transactions.
// Reset (rst_ni low, asynchronous) returns to header search with no result pending.
module escaped_field_message_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] data_byte, [17:8] param_length,
                                        // [35:18] count_value, [39:36] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] event_res
);

  logic              accept;
  logic              res_valid;
  logic              free;
  edfd_pkg::result_t res_core;
  edfd_pkg::result_t res_out;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  edfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res_core)
  );

  edfd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && res_valid),
    .res_i   (res_core),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .free_o  (free),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = {4'b0000, res_out.count_value, res_out.param_length,
                           res_out.data_byte};
  assign m_axis_tuser_o = res_out.event_res;

endmodule

>>> rtl/core/edfd_checker.sv
// Port-level checker for the deframer top level, bound to it.
module edfd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_o,
  input  logic [2:0]  m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result register full");

  a_flush_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> !m_axis_tvalid_o)
    else $error("flush transaction produced a result");

  a_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != edfd_pkg::EV_PAYLOAD) |->
      (m_axis_tdata_o[7:0] == 8'd0) && (m_axis_tdata_o[39:36] == 4'd0))
    else $error("unused result fields not zero");

endmodule

bind escaped_field_message_deframer_unit edfd_checker u_edfd_checker (.*);
